FILE: sv/bqdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdp_pkg
// Shared types, constants and fp32 arithmetic helpers for the block-quantized
// int8 dot product core.
// ----------------------------------------------------------------------------
package bqdp_pkg;

    localparam int unsigned IN_DATA_W   = 352;
    localparam int unsigned LANES       = 32;
    localparam int unsigned GROUPS      = 4;
    localparam int unsigned GROUP_LANES = 8;
    localparam int unsigned PSUM_W      = 12;
    localparam int unsigned ISUM_W      = 15;

    localparam logic [31:0] QNAN_BITS  = 32'h7fc00000;
    localparam logic [31:0] INF_MASK   = 32'h7f800000;
    localparam logic [7:0]  EXP_MAX    = 8'hff;
    localparam logic [10:0] ISUM_EXP   = 11'sd174;

    // Weight format codes
    localparam logic FMT_1BIT = 1'b0;
    localparam logic FMT_2BIT = 1'b1;

    typedef logic signed [PSUM_W-1:0] psum_t;

    typedef struct packed {
        psum_t [GROUPS-1:0] psum;
        logic [31:0]        ws;
        logic [31:0]        as_f;
        logic               last;
    } bqdp_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bqdp_qstat_t;

    // Unrounded fp result: either a finished special value or sign/exp/mantissa
    // with value = m * 2^(e - 174).
    typedef struct packed {
        logic               spec;
        logic [31:0]        bits;
        logic               s;
        logic signed [10:0] e;
        logic [47:0]        m;
    } bqdp_raw_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_RND1,
        BK_MUL2,
        BK_RND2,
        BK_ADD,
        BK_RND3
    } bqdp_state_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [9:0]  mn;
        logic [7:0]  e8;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        p   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                mn = man << (4'd10 - p);
                e8 = 8'd103 + {4'd0, p};
                r  = {h[15], e8, mn, 13'd0};
            end
        end else if (ex == 5'h1f) begin
            r = {h[15], 8'hff, man, 13'd0};
        end else begin
            r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                               input logic [47:0] m);
        logic [5:0]         lz;
        logic               found;
        logic [47:0]        mn;
        logic signed [10:0] ee;
        logic signed [10:0] amt;
        logic [5:0]         sh;
        logic               sticky;
        logic               rnd;
        logic [30:0]        body;
        logic [31:0]        r;
        lz    = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && m[i]) begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        mn     = m << lz;
        ee     = e - 11'($signed({5'd0, lz}));
        sticky = 1'b0;
        if (m == 48'd0) begin
            r = {s, 31'd0};
        end else if (ee >= 11'sd255) begin
            r = {s, EXP_MAX, 23'd0};
        end else begin
            if (ee <= 11'sd0) begin
                amt    = 11'sd1 - ee;
                sh     = (amt > 11'sd48) ? 6'd48 : amt[5:0];
                sticky = |(mn & ~({48{1'b1}} << sh));
                mn     = mn >> sh;
                ee     = 11'sd0;
            end
            rnd  = mn[23] & (sticky | (|mn[22:0]) | mn[24]);
            body = {ee[7:0], mn[46:24]} + {30'd0, rnd};
            r    = {s, body};
        end
        return r;
    endfunction

    function automatic bqdp_raw_t fmul_raw(input logic [31:0] a, input logic [31:0] b);
        logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [23:0] ma, mb;
        logic [7:0]  ea, eb;
        bqdp_raw_t   r;
        nan_a  = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nan_b  = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        inf_a  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        inf_b  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        r.s    = a[31] ^ b[31];
        r.e    = 11'($signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126);
        r.m    = ma * mb;
        r.spec = 1'b0;
        r.bits = QNAN_BITS;
        if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
            r.spec = 1'b1;
        end else if (inf_a || inf_b) begin
            r.spec = 1'b1;
            r.bits = {r.s, EXP_MAX, 23'd0};
        end
        return r;
    endfunction

    function automatic bqdp_raw_t fadd_raw(input logic [31:0] a, input logic [31:0] b);
        logic        nan_a, nan_b, inf_a, inf_b, swap;
        logic [23:0] ma, mb, mbig, msml;
        logic [7:0]  ea, eb, ebig, d;
        logic        sbig;
        logic [47:0] fa, fb, bs;
        logic        st;
        bqdp_raw_t   r;
        nan_a = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        ma    = {a[30:23] != 8'd0, a[22:0]};
        mb    = {b[30:23] != 8'd0, b[22:0]};
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        swap  = (ea < eb) || ((ea == eb) && (ma < mb));
        mbig  = swap ? mb : ma;
        msml  = swap ? ma : mb;
        ebig  = swap ? eb : ea;
        sbig  = swap ? b[31] : a[31];
        d     = swap ? (eb - ea) : (ea - eb);
        fa    = {1'b0, mbig, 23'd0};
        fb    = {1'b0, msml, 23'd0};
        if (d >= 8'd48) begin
            bs = 48'd0;
            st = |fb;
        end else begin
            bs = fb >> d;
            st = |(fb & ~({48{1'b1}} << d));
        end
        bs[0] = bs[0] | st;
        r.m   = (a[31] == b[31]) ? (fa + bs) : (fa - bs);
        r.s   = (r.m == 48'd0) ? (a[31] & b[31]) : sbig;
        r.e   = 11'($signed({3'd0, ebig}) + 11'sd1);
        r.spec = 1'b0;
        r.bits = QNAN_BITS;
        if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
            r.spec = 1'b1;
        end else if (inf_a) begin
            r.spec = 1'b1;
            r.bits = a;
        end else if (inf_b) begin
            r.spec = 1'b1;
            r.bits = b;
        end
        return r;
    endfunction

    function automatic logic [31:0] finish(input bqdp_raw_t r);
        return r.spec ? r.bits : round_pack(r.s, r.e, r.m);
    endfunction

endpackage

FILE: sv/block_quant_dot_product_core.sv
`timescale 1ns / 1ps
// The back end takes one chunk at a time from the queue and finishes it in the fp32
// sequencer (two multiplies, one add, each followed by a round/normalize state) before
// it pops the next; on a last chunk RND3 waits until the output register can take it.
// The front end takes chunks while a two-entry queue has room.
// Reset (aresetn low, synchronous) clears the queue, the accumulator to +0,
// the output valid and the weight format to 1-bit codes.
// ----------------------------------------------------------------------------
// block_quant_dot_product_core
// Block-quantized int8 dot product with fp32 scaled accumulation.
// ----------------------------------------------------------------------------
module block_quant_dot_product_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,   // weight_format
    input  logic         s_tvalid,
    output logic         s_tready,
    // weight_codes[63:0], weight_scale[79:64], acts_0_7[143:80], acts_8_15[207:144],
    // acts_16_23[271:208], acts_24_31[335:272], act_scale[351:336]
    input  logic [351:0] s_tdata,
    input  logic         s_tlast,    // last_chunk
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata     // dot_bits[31:0]
);

    logic                  fmt_reg, fmt_next;
    logic                  push, pop, emit;
    bqdp_pkg::bqdp_entry_t entry, head;
    bqdp_pkg::bqdp_qstat_t qstat;

    assign cfg_ready = 1'b1;
    assign fmt_next  = (cfg_valid && cfg_ready) ? cfg_data : fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= bqdp_pkg::FMT_1BIT;
        end else begin
            fmt_reg <= fmt_next;
        end
    end

    bqdp_front u_front (
        .weight_format (fmt_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .qstat         (qstat),
        .push          (push),
        .entry         (entry)
    );

    bqdp_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (entry),
        .pop     (pop),
        .dout    (head),
        .qstat   (qstat)
    );

    bqdp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .emit     (emit),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !qstat.full)
        else $error("transaction accepted into a full queue");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid)
        else $error("result emitted but output not valid");

endmodule

FILE: sv/bqdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdp_front
// Accepts chunks, decodes weights, forms four partial lane sums and converts
// both fp16 scales to fp32 before pushing into the work queue.
// ----------------------------------------------------------------------------
module bqdp_front (
    input  logic                              weight_format,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bqdp_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    input  bqdp_pkg::bqdp_qstat_t             qstat,
    output logic                              push,
    output bqdp_pkg::bqdp_entry_t             entry
);

    logic [63:0]  codes;
    logic [255:0] acts;

    function automatic logic signed [9:0] lane_prod(input logic fmt, input logic [1:0] c2,
                                                    input logic c1, input logic [7:0] a);
        logic signed [9:0] av;
        logic signed [9:0] p;
        av = $signed({{2{a[7]}}, a});
        if (fmt == bqdp_pkg::FMT_1BIT) begin
            p = c1 ? av : -av;
        end else begin
            case (c2)
                2'd0:    p = -av;
                2'd1:    p = 10'sd0;
                2'd2:    p = av;
                default: p = av <<< 1;
            endcase
        end
        return p;
    endfunction

    assign codes = s_tdata[63:0];
    assign acts  = {s_tdata[335:272], s_tdata[271:208], s_tdata[207:144], s_tdata[143:80]};

    always_comb begin
        for (int g = 0; g < bqdp_pkg::GROUPS; g++) begin
            entry.psum[g] = '0;
            for (int k = 0; k < bqdp_pkg::GROUP_LANES; k++) begin
                entry.psum[g] = entry.psum[g] + bqdp_pkg::PSUM_W'(lane_prod(
                    weight_format,
                    codes[2*(g*8+k) +: 2],
                    codes[g*8+k],
                    acts[8*(g*8+k) +: 8]));
            end
        end
        entry.ws   = bqdp_pkg::half_to_single(s_tdata[79:64]);
        entry.as_f = bqdp_pkg::half_to_single(s_tdata[351:336]);
        entry.last = s_tlast;
    end

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;

endmodule

FILE: sv/bqdp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdp_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module bqdp_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bqdp_pkg::bqdp_entry_t  din,
    input  logic                   pop,
    output bqdp_pkg::bqdp_entry_t  dout,
    output bqdp_pkg::bqdp_qstat_t  qstat
);

    bqdp_pkg::bqdp_entry_t mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

    assign dout        = mem_reg[rptr_reg];
    assign qstat.full  = cnt_reg == 2'd2;
    assign qstat.empty = cnt_reg == 2'd0;

endmodule

FILE: sv/bqdp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdp_back
// Sequencer that scales the integer sum and accumulates in fp32, then
// presents the result on the output register for the last chunk.
// ----------------------------------------------------------------------------
module bqdp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bqdp_pkg::bqdp_entry_t  head,
    input  bqdp_pkg::bqdp_qstat_t  qstat,
    output logic                   pop,
    output logic                   emit,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata
);

    bqdp_pkg::bqdp_state_t state_reg, state_next;

    logic signed [bqdp_pkg::ISUM_W-1:0] isum_reg;
    logic [31:0]          ws_reg, as_reg, isf_reg, op_reg, acc_reg, acc_next;
    logic                 last_reg;
    bqdp_pkg::bqdp_raw_t  raw_reg;
    logic                 ov_reg, ov_next;
    logic [31:0]          od_reg;
    logic [31:0]          res;
    logic                 can_emit;
    logic [bqdp_pkg::ISUM_W-1:0] isum_abs;
    logic signed [bqdp_pkg::ISUM_W-1:0] isum_new;

    assign res      = bqdp_pkg::finish(raw_reg);
    assign can_emit = !ov_reg || m_tready;
    assign isum_abs = isum_reg[bqdp_pkg::ISUM_W-1] ? -isum_reg : isum_reg;

    always_comb begin
        isum_new = '0;
        for (int g = 0; g < bqdp_pkg::GROUPS; g++) begin
            isum_new = isum_new + bqdp_pkg::ISUM_W'(head.psum[g]);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bqdp_pkg::BK_IDLE: if (!qstat.empty) state_next = bqdp_pkg::BK_MUL1;
            bqdp_pkg::BK_MUL1: state_next = bqdp_pkg::BK_RND1;
            bqdp_pkg::BK_RND1: state_next = bqdp_pkg::BK_MUL2;
            bqdp_pkg::BK_MUL2: state_next = bqdp_pkg::BK_RND2;
            bqdp_pkg::BK_RND2: state_next = bqdp_pkg::BK_ADD;
            bqdp_pkg::BK_ADD:  state_next = bqdp_pkg::BK_RND3;
            bqdp_pkg::BK_RND3: if (!last_reg || can_emit) state_next = bqdp_pkg::BK_IDLE;
            default:           state_next = bqdp_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop      = 1'b0;
        emit     = 1'b0;
        acc_next = acc_reg;
        ov_next  = ov_reg && !m_tready;
        case (state_reg)
            bqdp_pkg::BK_IDLE: pop = !qstat.empty;
            bqdp_pkg::BK_RND3: begin
                if (!last_reg) begin
                    acc_next = res;
                end else if (can_emit) begin
                    emit     = 1'b1;
                    acc_next = 32'd0;
                    ov_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bqdp_pkg::BK_IDLE;
            acc_reg   <= 32'd0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            od_reg <= res;
        end
        case (state_reg)
            bqdp_pkg::BK_IDLE: begin
                isum_reg <= isum_new;
                ws_reg   <= head.ws;
                as_reg   <= head.as_f;
                last_reg <= head.last;
            end
            bqdp_pkg::BK_MUL1: begin
                raw_reg <= bqdp_pkg::fmul_raw(ws_reg, as_reg);
                isf_reg <= bqdp_pkg::round_pack(isum_reg[bqdp_pkg::ISUM_W-1],
                                                bqdp_pkg::ISUM_EXP,
                                                {{(48-bqdp_pkg::ISUM_W){1'b0}}, isum_abs});
            end
            bqdp_pkg::BK_RND1: op_reg  <= res;
            bqdp_pkg::BK_MUL2: raw_reg <= bqdp_pkg::fmul_raw(op_reg, isf_reg);
            bqdp_pkg::BK_RND2: op_reg  <= res;
            bqdp_pkg::BK_ADD:  raw_reg <= bqdp_pkg::fadd_raw(acc_reg, op_reg);
            default: ;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

endmodule

FILE: sim/tb_block_quant_dot_product_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_quant_dot_product_core
// Streams 32-element chunks through the core in both weight formats. A bit-exact
// fp32 accumulator model predicts every emitted dot product. Both stream sides
// idle and stall at random (except in one phase), and the format is changed between phases.
// ----------------------------------------------------------------------------
module tb_block_quant_dot_product_core;

    class dot_scoreboard;
        logic        fmt;
        logic [31:0] acc_bits;
        logic [31:0] dot_fifo[$];

        function new();
            fmt      = bqdp_pkg::FMT_1BIT;
            acc_bits = 32'd0;
        endfunction

        // Round m * 2^e to fp32, nearest even, with subnormals and overflow.
        function automatic logic [31:0] fp32_round(logic s, int e, logic [319:0] m);
            int           p;
            int           sh;
            int           be;
            logic [319:0] q;
            logic [319:0] rem;
            logic [319:0] half;
            logic [31:0]  r;
            if (m == 320'd0) return {s, 31'd0};
            p = 0;
            for (int i = 0; i < 320; i++) if (m[i]) p = i;
            sh = p - 23;
            if (sh < -149 - e) sh = -149 - e;
            if (sh > 0) begin
                q    = m >> sh;
                rem  = m & ((320'd1 << sh) - 320'd1);
                half = 320'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 320'd1;
            end else begin
                q = m << (-sh);
            end
            if (q[24]) begin
                q  = q >> 1;
                sh = sh + 1;
            end
            if (!q[23]) begin
                r = {s, 8'd0, q[22:0]};
            end else begin
                be = e + sh + 150;
                r  = (be >= 255) ? {s, 8'hff, 23'd0} : {s, be[7:0], q[22:0]};
            end
            return r;
        endfunction

        function automatic logic [31:0] half_to_fp32(logic [15:0] h);
            if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
            if (h[14:10] == 5'd0) return fp32_round(h[15], -24, {310'd0, h[9:0]});
            return fp32_round(h[15], int'(h[14:10]) - 25, {309'd0, 1'b1, h[9:0]});
        endfunction

        function automatic bit is_nan(logic [31:0] a);
            return a[30:23] == 8'hff && a[22:0] != 23'd0;
        endfunction

        function automatic bit is_inf(logic [31:0] a);
            return a[30:23] == 8'hff && a[22:0] == 23'd0;
        endfunction

        function automatic int exp_of(logic [31:0] a);
            return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
        endfunction

        function automatic logic [23:0] man_of(logic [31:0] a);
            return {a[30:23] != 8'd0, a[22:0]};
        endfunction

        function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
            logic s;
            s = a[31] ^ b[31];
            if (is_nan(a) || is_nan(b)) return bqdp_pkg::QNAN_BITS;
            if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
                return bqdp_pkg::QNAN_BITS;
            if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'd0};
            return fp32_round(s, exp_of(a) + exp_of(b),
                              {272'd0, 48'(man_of(a)) * 48'(man_of(b))});
        endfunction

        function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
            int           ea;
            int           eb;
            int           emin;
            logic [319:0] ma;
            logic [319:0] mb;
            if (is_nan(a) || is_nan(b)) return bqdp_pkg::QNAN_BITS;
            if (is_inf(a) && is_inf(b) && a[31] != b[31]) return bqdp_pkg::QNAN_BITS;
            if (is_inf(a)) return a;
            if (is_inf(b)) return b;
            ea   = exp_of(a);
            eb   = exp_of(b);
            emin = (ea < eb) ? ea : eb;
            ma   = {296'd0, man_of(a)} << (ea - emin);
            mb   = {296'd0, man_of(b)} << (eb - emin);
            if (a[31] == b[31]) return fp32_round(a[31], emin, ma + mb);
            if (ma == mb) return {a[31] & b[31], 31'd0};
            if (ma > mb) return fp32_round(a[31], emin, ma - mb);
            return fp32_round(b[31], emin, mb - ma);
        endfunction

        // Take one accepted chunk: update the accumulator, queue a result on last.
        function void note_chunk(logic [351:0] d, logic last);
            int          isum;
            int          w;
            int          act;
            logic [31:0] sp;
            logic [31:0] term;
            isum = 0;
            for (int j = 0; j < 32; j++) begin
                if (fmt == bqdp_pkg::FMT_2BIT) w = int'(d[2*j +: 2]) - 1;
                else w = 2 * int'(d[j]) - 1;
                act  = int'($signed(d[80 + 8*j +: 8]));
                isum = isum + w * act;
            end
            sp   = fp32_mul(half_to_fp32(d[79:64]), half_to_fp32(d[351:336]));
            term = fp32_mul(sp, fp32_round(isum < 0, 0,
                                           {288'd0, 32'(isum < 0 ? -isum : isum)}));
            acc_bits = fp32_add(acc_bits, term);
            if (last) begin
                dot_fifo.push_back(acc_bits);
                acc_bits = 32'd0;
            end
        endfunction

        // Returns 0 if no result was waiting, 1 on match, 2 on mismatch.
        function int check_dot(logic [31:0] got, output logic [31:0] want);
            want = 32'hx;
            if (dot_fifo.size() == 0) return 0;
            want = dot_fifo.pop_front();
            return (got === want) ? 1 : 2;
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [351:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    dot_scoreboard sb;
    int            errors;
    int            sink_wait;
    bit            no_idle;

    block_quant_dot_product_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Result sink with random stalls after each transaction
    always @(posedge aclk) begin
        int          rc;
        int          nxt;
        logic [31:0] want;
        nxt = sink_wait;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rc = sb.check_dot(m_tdata, want);
                if (rc == 0) report($sformatf("unexpected result %h", m_tdata));
                else if (rc == 2) report($sformatf("dot_bits %h, want %h", m_tdata, want));
                nxt = no_idle ? 0 : $urandom_range(0, 14);
            end else if (nxt > 0) begin
                nxt--;
            end
            sink_wait = nxt;
            m_tready <= (nxt == 0);
        end
    end

    task automatic write_format(logic v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.fmt = v;
    endtask

    task automatic send_chunk(logic [63:0] codes, logic [15:0] ws, logic [255:0] acts,
                              logic [15:0] as_h, logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {as_h, acts, ws, codes};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_chunk({as_h, acts, ws, codes}, last);
    endtask

    // Drain results, then let the back end go quiet before touching the register
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.dot_fifo.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_scale();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 9))
            6:       h[14:10] = 5'd0;
            7:       h[14:0] = 15'd0;
            8:       h[14:10] = 5'h1f;
            9:       ;
            default: h[14:10] = 5'($urandom_range(5, 25));
        endcase
        return h;
    endfunction

    function automatic logic [255:0] rand_acts();
        logic [255:0] a;
        for (int k = 0; k < 8; k++) a[32*k +: 32] = $urandom;
        return a;
    endfunction

    initial begin
        #2_000_000;
        $display("block_quant_dot_product_core regression: fail");
        $finish;
    end

    initial begin
        sb        = new();
        errors    = 0;
        sink_wait = 0;
        no_idle   = 0;
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme codes and activations, special fp16 scales
        for (int f = 0; f < 2; f++) begin
            write_format(f[0]);
            send_chunk('1, 16'h3c00, {32{8'h7f}}, 16'h3c00, 1'b1);
            send_chunk('0, 16'h3c00, {32{8'h80}}, 16'h3c00, 1'b1);
            send_chunk({32'hffff_ffff, 32'h0}, 16'h7bff, {32{8'h80}}, 16'h7bff, 1'b0);
            send_chunk(64'h5555_5555_aaaa_aaaa, 16'h0001, rand_acts(), 16'h03ff, 1'b1);
            send_chunk(64'h0123_4567_89ab_cdef, 16'h0000, rand_acts(), 16'h7c00, 1'b1);
            send_chunk('1, 16'h7c00, rand_acts(), 16'h3c00, 1'b0);
            send_chunk('0, 16'hfc00, rand_acts(), 16'h3c00, 1'b1);
            send_chunk('1, 16'h7e00, rand_acts(), 16'h8000, 1'b1);
            send_chunk('1, 16'h8001, rand_acts(), 16'h0001, 1'b1);
            send_chunk('0, 16'hffff, rand_acts(), 16'h7fff, 1'b1);
            drain();
        end

        // Random phases, alternating formats, one phase without idling
        for (int ph = 0; ph < 6; ph++) begin
            write_format(ph[0]);
            no_idle = (ph == 3);
            for (int n = 0; n < 100; n++) begin
                send_chunk({$urandom, $urandom}, pick_scale(), rand_acts(), pick_scale(),
                           (n == 99) || ($urandom_range(0, 3) == 0));
                if (n == 50) drain();
            end
            drain();
        end
        no_idle = 0;

        if (errors == 0) begin
            $display("block_quant_dot_product_core regression: pass");
        end else begin
            $display("block_quant_dot_product_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/bqdp_pkg.sv
sv/bqdp_front.sv
sv/bqdp_fifo.sv
sv/bqdp_back.sv
sv/block_quant_dot_product_core.sv
sim/tb_block_quant_dot_product_core.sv
